// File: rtl/hmle_pkg.sv
// shared constants, types and hash multiplier constants for the hash map lookup engine
package hmle_pkg;

    localparam int BUCKET_COUNT     = 64;
    localparam int SLOTS_PER_BUCKET = 8;
    localparam int VALUE_BITS       = 32;
    localparam int TOTAL_SLOTS      = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int BUCKET_BITS      = $clog2(BUCKET_COUNT);
    localparam int SLOT_BITS        = $clog2(SLOTS_PER_BUCKET);
    localparam int ADDR_BITS        = $clog2(TOTAL_SLOTS);
    localparam int FILL_BITS        = $clog2(SLOTS_PER_BUCKET + 1);
    localparam int COUNT_BITS       = 10;
    localparam int KEY_BITS         = 64;
    localparam int HASH_BITS        = 32;

    localparam logic [1:0] FUNC_PUT      = 2'd0;
    localparam logic [1:0] FUNC_GET      = 2'd1;
    localparam logic [1:0] FUNC_REMOVE   = 2'd2;
    localparam logic [1:0] FUNC_RESERVED = 2'd3;

    localparam logic [31:0] C32_A = 32'h85ebca6b;
    localparam logic [31:0] C32_B = 32'hc2b2ae35;
    localparam logic [63:0] C64_A = 64'hff51afd7ed558ccd;
    localparam logic [63:0] C64_B = 64'hc4ceb9fe1a85ec53;

    typedef struct packed {
        logic [1:0]            func;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
        logic [HASH_BITS-1:0]  hash;
    } hmle_cmd_t;

endpackage

// File: rtl/hmle_ram.sv
// generic single-write, single-read ram with registered read
module hmle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/hmle_front.sv
// front end: accepts requests, hashes the key over sequential multiply steps
module hmle_front import hmle_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  key_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_func,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    output logic                  cmd_valid,
    input  logic                  cmd_ready,
    output hmle_cmd_t             cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_M1   = 3'd1;
    localparam logic [2:0] S_M1B  = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_M2B  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic                  mode_reg;
    logic [1:0]            func_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [63:0]           x_reg, x_next;
    logic [63:0]           lo_reg;
    logic [31:0]           cross_reg;
    logic [63:0]           mult_c;
    logic [31:0]           a_lo, a_hi, b_lo, b_hi;
    logic [63:0]           p_ll, p_lh, p_hl;
    logic [63:0]           prod;

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd_valid = (state_reg == S_DONE);

    always_comb begin
        cmd.func  = func_reg;
        cmd.key   = key_reg;
        cmd.value = value_reg;
        cmd.hash  = x_reg[31:0];
    end

    // 64x64 low product split into 32x32 partials, registered in S_M1/S_M2 and summed in S_M1B/S_M2B
    assign mult_c = (state_reg == S_M1 || state_reg == S_M1B) ?
                    (mode_reg ? C64_A : {32'd0, C32_A}) :
                    (mode_reg ? C64_B : {32'd0, C32_B});
    assign a_lo = x_reg[31:0];
    assign a_hi = x_reg[63:32];
    assign b_lo = mult_c[31:0];
    assign b_hi = mult_c[63:32];
    assign p_ll = a_lo * b_lo;
    assign p_lh = a_lo * b_hi;
    assign p_hl = a_hi * b_lo;
    assign prod = lo_reg + {cross_reg, 32'd0};

    always_comb begin
        state_next = state_reg;
        x_next     = x_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_M1;
                    if (key_mode) begin
                        x_next = in_key ^ (in_key >> 33);
                    end else begin
                        x_next = {32'd0, in_key[31:0] ^ (in_key[31:0] >> 16)};
                    end
                end
            end
            S_M1: begin
                state_next = S_M1B;
            end
            S_M2: begin
                state_next = S_M2B;
            end
            S_M1B: begin
                if (mode_reg) begin
                    x_next = prod ^ (prod >> 33);
                end else begin
                    x_next = {32'd0, prod[31:0] ^ (prod[31:0] >> 13)};
                end
                state_next = S_M2;
            end
            S_M2B: begin
                if (mode_reg) begin
                    x_next = prod ^ (prod >> 33);
                end else begin
                    x_next = {32'd0, prod[31:0] ^ (prod[31:0] >> 16)};
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (cmd_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == S_IDLE && in_valid) begin
            mode_reg  <= key_mode;
            func_reg  <= in_func;
            key_reg   <= key_mode ? in_key : {32'd0, in_key[31:0]};
            value_reg <= in_value;
        end
        x_reg <= x_next;
        if (state_reg == S_M1 || state_reg == S_M2) begin
            lo_reg    <= p_ll;
            cross_reg <= p_lh[31:0] + p_hl[31:0];
        end
    end
endmodule

// File: rtl/hmle_back.sv
// back end: bucket scan, update of slot memories and result register
module hmle_back import hmle_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    input  hmle_cmd_t             cmd,
    output logic                  res_valid,
    input  logic                  res_ready,
    output logic                  res_found,
    output logic [31:0]           res_value,
    output logic                  res_status,
    output logic [COUNT_BITS-1:0] res_count
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_MOVE2 = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    localparam int ENTRY_BITS = KEY_BITS + VALUE_BITS + HASH_BITS;

    logic [2:0]             state_reg, state_next;
    hmle_cmd_t              cmd_reg;
    logic [BUCKET_COUNT-1:0] fill_valid_reg;
    logic [FILL_BITS-1:0]   fill, fill_rdata, fill_wdata;
    logic                   fill_we, fill_inc;
    logic [BUCKET_BITS-1:0] fill_raddr;
    logic [BUCKET_BITS-1:0] bucket;
    logic [FILL_BITS-1:0]   idx_reg;
    logic [SLOT_BITS-1:0]   hit_reg;
    logic [COUNT_BITS-1:0]  total_reg;
    logic                   found_reg, status_reg;
    logic [31:0]            vout_reg;
    logic                   we;
    logic [ADDR_BITS-1:0]   waddr, raddr;
    logic [ENTRY_BITS-1:0]  wdata, rdata;
    logic [KEY_BITS-1:0]    r_key;
    logic [VALUE_BITS-1:0]  r_value;
    logic [HASH_BITS-1:0]   r_hash;
    logic                   match;

    assign bucket = cmd_reg.hash[BUCKET_BITS-1:0];
    assign fill   = fill_valid_reg[bucket] ? fill_rdata : '0;
    assign {r_key, r_value, r_hash} = rdata;
    assign match = (r_hash == cmd_reg.hash) && (r_key == cmd_reg.key);

    assign cmd_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);
    assign res_found  = found_reg;
    assign res_value  = vout_reg;
    assign res_status = status_reg;
    assign res_count  = total_reg;

    // bucket fill read from the incoming command's hash while idle, ahead of the scan
    assign fill_raddr = (state_reg == S_IDLE) ? cmd.hash[BUCKET_BITS-1:0] : bucket;
    assign fill_inc   = we && state_reg != S_MOVE2 && !(state_reg == S_CHECK && match);
    assign fill_we    = fill_inc || state_reg == S_MOVE;
    assign fill_wdata = (state_reg == S_MOVE) ? fill - 1'b1 : fill + 1'b1;

    hmle_ram #(.WIDTH(FILL_BITS), .DEPTH(BUCKET_COUNT)) u_fill (
        .aclk (aclk),
        .we   (fill_we),
        .waddr(bucket),
        .wdata(fill_wdata),
        .raddr(fill_raddr),
        .rdata(fill_rdata)
    );

    hmle_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TOTAL_SLOTS)) u_slots (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb begin
        raddr = {bucket, idx_reg[SLOT_BITS-1:0]};
        if (state_reg == S_CHECK && !match) begin
            raddr = {bucket, SLOT_BITS'(idx_reg + 1'b1)};
        end
        if (state_reg == S_CHECK && match) begin
            raddr = {bucket, SLOT_BITS'(fill - 1'b1)};
        end
        if (state_reg == S_MOVE) begin
            raddr = {bucket, SLOT_BITS'(fill - 1'b1)};
        end
    end

    always_comb begin
        state_next = state_reg;
        we    = 1'b0;
        waddr = {bucket, hit_reg};
        wdata = {cmd_reg.key, cmd_reg.value, cmd_reg.hash};
        unique case (state_reg)
            S_IDLE: if (cmd_valid) state_next = S_READ;
            S_READ: state_next = (fill == '0) ? S_OUT : S_CHECK;
            S_CHECK: begin
                if (match) begin
                    if (cmd_reg.func == FUNC_PUT) begin
                        we    = 1'b1;
                        waddr = {bucket, idx_reg[SLOT_BITS-1:0]};
                        wdata = {r_key, cmd_reg.value, r_hash};
                        state_next = S_OUT;
                    end else if (cmd_reg.func == FUNC_REMOVE) begin
                        state_next = S_MOVE;
                    end else begin
                        state_next = S_OUT;
                    end
                end else if (idx_reg + 1'b1 >= fill) begin
                    state_next = S_OUT;
                end
            end
            S_MOVE: state_next = S_MOVE2;
            S_MOVE2: begin
                we    = 1'b1;
                waddr = {bucket, hit_reg};
                wdata = rdata;
                state_next = S_OUT;
            end
            S_OUT: if (res_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_CHECK && !match && idx_reg + 1'b1 >= fill
            && cmd_reg.func == FUNC_PUT && fill < FILL_BITS'(SLOTS_PER_BUCKET)) begin
            we    = 1'b1;
            waddr = {bucket, fill[SLOT_BITS-1:0]};
        end
        if (state_reg == S_READ && fill == '0 && cmd_reg.func == FUNC_PUT) begin
            we    = 1'b1;
            waddr = {bucket, {SLOT_BITS{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            total_reg      <= '0;
            fill_valid_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (fill_we) begin
                fill_valid_reg[bucket] <= 1'b1;
            end
            if (fill_inc) begin
                total_reg <= total_reg + 1'b1;
            end
            if (state_reg == S_MOVE) begin
                total_reg <= total_reg - 1'b1;
            end
        end
        if (state_reg == S_IDLE && cmd_valid) begin
            cmd_reg    <= cmd;
            idx_reg    <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            vout_reg   <= '0;
        end
        if (state_reg == S_CHECK) begin
            if (match) begin
                found_reg <= (cmd_reg.func != FUNC_RESERVED);
                hit_reg   <= idx_reg[SLOT_BITS-1:0];
                if (cmd_reg.func == FUNC_GET) begin
                    vout_reg <= 32'(r_value);
                end
            end else begin
                idx_reg <= idx_reg + 1'b1;
                if (idx_reg + 1'b1 >= fill && cmd_reg.func == FUNC_PUT
                    && fill >= FILL_BITS'(SLOTS_PER_BUCKET)) begin
                    status_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn && state_reg == S_OUT) begin
            assert (!(res_status && res_found))
                else $error("drop flagged on a hit");
        end
    end

    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOVE |=> total_reg == $past(total_reg) - 1'b1)
        else $error("remove did not lower count");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res_ready |=> res_valid && $stable(res_count))
        else $error("result changed while stalled");
    a_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !we)
        else $error("write while idle");
endmodule

// File: rtl/hash_map_lookup_engine.sv
// top level of the hash map lookup engine: front hash stage, queue, back table engine
//
// channel  dir  fields (tdata low bit up)                    tuser
// s_axis   in   func[1:0], key[65:2], value[97:66], pad     -
// m_axis   out  value_out[31:0], entry_count[41:32], pad    found[0], status[1]
//
// the front takes a request through accept, four multiply steps and hand-off to the queue
// the back takes a request through a fill read, a check per slot scanned, two move states for a remove
// that hits, and the result state, where it holds until the result is taken
// the two-entry queue lets the front hash the next request while the back scans
// reset clears the bucket valid bits and the entry count; fill and slot memories are not cleared
// m_axis_tready low holds the result and the back; the queue fills, then the front stops
module hash_map_lookup_engine import hmle_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // func, key, value
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,  // value_out, entry_count
    output logic [1:0]   m_axis_tuser   // found, status
);
    logic      mode_reg;
    logic      f_valid, f_ready, b_ready;
    hmle_cmd_t f_cmd, q_cmd_reg [2];
    logic [1:0] q_cnt_reg;
    logic      q_rd_reg, q_wr_reg;
    logic      found, status;
    logic [31:0] vout;
    logic [COUNT_BITS-1:0] cnt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata[0];
        end
    end

    hmle_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key_mode (mode_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_func  (s_axis_tdata[1:0]),
        .in_key   (s_axis_tdata[65:2]),
        .in_value (s_axis_tdata[97:66]),
        .cmd_valid(f_valid),
        .cmd_ready(f_ready),
        .cmd      (f_cmd)
    );

    assign f_ready = (q_cnt_reg != 2'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_cnt_reg <= '0;
            q_rd_reg  <= 1'b0;
            q_wr_reg  <= 1'b0;
        end else begin
            if (f_valid && f_ready) q_wr_reg <= ~q_wr_reg;
            if (q_cnt_reg != 2'd0 && b_ready) q_rd_reg <= ~q_rd_reg;
            q_cnt_reg <= q_cnt_reg + {1'b0, f_valid && f_ready}
                         - {1'b0, q_cnt_reg != 2'd0 && b_ready};
        end
        if (f_valid && f_ready) q_cmd_reg[q_wr_reg] <= f_cmd;
    end

    hmle_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (q_cnt_reg != 2'd0),
        .cmd_ready (b_ready),
        .cmd       (q_cmd_reg[q_rd_reg]),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_found (found),
        .res_value (vout),
        .res_status(status),
        .res_count (cnt)
    );

    assign m_axis_tdata = {6'd0, cnt, vout};
    assign m_axis_tuser = {status, found};
endmodule
